// ----- sv/hdbc_pkg.sv -----
// ----------------------------------------------------------------------------
// hdbc_pkg
// Shared types and constants for the half-duplex bus collision MAC.
// ----------------------------------------------------------------------------
package hdbc_pkg;

    localparam int RX_DEPTH_DEF = 16;
    localparam int TX_DEPTH_DEF = 32;

    // backoff random generator
    localparam int RAND_ADD   = 251;
    localparam int SLOT_SCALE = 16;

    // register reset values
    localparam logic [15:0] ITO_RST  = 16'd8;
    localparam logic [7:0]  TPM_RST  = 8'd4;
    localparam logic [4:0]  MAXR_RST = 5'd16;
    localparam logic [3:0]  JAML_RST = 4'd8;
    localparam logic [7:0]  SEED_RST = 8'd0;

    localparam logic [4:0] RETRY_SAT = 5'd31;
    localparam logic [3:0] JAM_SAT   = 4'd15;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_ITO  = 3'd0,
        CFG_TPM  = 3'd1,
        CFG_MAXR = 3'd2,
        CFG_JAML = 3'd3,
        CFG_SEED = 3'd4
    } t_cfg_idx;

    // request kinds
    typedef enum logic [2:0] {
        MD_LOAD  = 3'd0,
        MD_SEND  = 3'd1,
        MD_LINE  = 3'd2,
        MD_TICK  = 3'd3,
        MD_TXRDY = 3'd4,
        MD_TXDN  = 3'd5,
        MD_START = 3'd6,
        MD_READ  = 3'd7
    } t_mode;

    typedef enum logic [2:0] {
        LM_IDLE = 3'd0,
        LM_RX   = 3'd1,
        LM_TX   = 3'd2,
        LM_STOP = 3'd3,
        LM_PEND = 3'd4,
        LM_JAM  = 3'd5
    } t_line;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_MUL,
        ST_SUM
    } t_state;

endpackage

// ----- sv/half_duplex_bus_collision_mac_core.sv -----
// ----------------------------------------------------------------------------
// half_duplex_bus_collision_mac_core
// Collision-detecting MAC for a shared half-duplex byte bus.
// ----------------------------------------------------------------------------
// Usage:
//  Slave stream: one request per beat. tuser carries the request kind (load
//  frame byte, send, line byte, tick, tx ready, tx done, start bit, host
//  read); tdata carries the byte and the start-bit-pending flag.
//  Master stream: exactly one result beat per request, holding the tx byte,
//  driver enable, rx byte, accept flag, line state, drop flag and rx count.
//  Config channel: register index plus data, always ready; write only while
//  the block is idle.
//  Result: registered at the end of the execute state entered on acceptance
//  (frame store and receive FIFO are read at the accepting edge, the update
//  and write-back run in the following cycle). A timer tick that starts a
//  backoff then runs on in the background (the bit-serial remainder, a
//  multiply, then an add, with the delay written at the end) before the
//  next request.
//  One request at a time: none is taken until execution and any backoff end.
//  The master register holds its result while the receiver stalls; no new
//  request is taken until it has gone.
//  Reset: synchronous, active low; line idle, empty frame and FIFO, register
//  defaults loaded. Memories are not cleared.
// ----------------------------------------------------------------------------
module half_duplex_bus_collision_mac_core #(
    parameter int RX_DEPTH = hdbc_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH = hdbc_pkg::TX_DEPTH_DEF,
    localparam int RXW = $clog2(RX_DEPTH),
    localparam int OW  = ((24 + RXW + 7) / 8) * 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // request stream
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [15:0]   i_s_tdata,   // [7:0] data, [8] start_bit_pending
    input  logic [2:0]    i_s_tuser,   // [2:0] mode
    // result stream
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // [0] tx_valid, [8:1] tx_byte, [9] driver_enable, [10] rx_valid,
    // [18:11] rx_byte, [19] accepted, [22:20] line_state, [23] frame_dropped,
    // [24+RXW-1:24] rx_count
    output logic [OW-1:0] o_m_tdata,
    // configuration
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data
);

    localparam int STORE_DEPTH = TX_DEPTH - 1;
    localparam int TXW = $clog2(TX_DEPTH);    // holds 0..STORE_DEPTH
    localparam int SAW = $clog2(STORE_DEPTH); // store address
    localparam logic [TXW-1:0] STORE_MAX = TXW'(STORE_DEPTH);
    localparam logic [RXW-1:0] RX_LAST   = RXW'(RX_DEPTH - 1);
    localparam logic [RXW:0]   RX_D      = (RXW + 1)'(RX_DEPTH);

    // memories
    logic [7:0] r_store [STORE_DEPTH];
    logic [7:0] r_fifo  [RX_DEPTH];

    // control
    hdbc_pkg::t_state r_state, n_state;
    hdbc_pkg::t_line  r_line,  n_line;

    logic [15:0]    r_ito;
    logic [7:0]     r_tpm;
    logic [4:0]     r_maxr;
    logic [3:0]     r_jaml;

    logic [TXW-1:0] r_flen, n_flen;
    logic [TXW-1:0] r_sidx, n_sidx;
    logic [TXW-1:0] r_cidx, n_cidx;
    logic           r_active, n_active;
    logic           r_first, n_first;
    logic           r_armed, n_armed;
    logic           r_drv, n_drv;
    logic [4:0]     r_retry, n_retry;
    logic [3:0]     r_jam, n_jam;
    logic [15:0]    r_pdly, n_pdly;
    logic [15:0]    r_trem, n_trem;
    logic           r_trun, n_trun;
    logic [15:0]    r_rand, n_rand;
    logic [RXW-1:0] r_wp, n_wp;
    logic [RXW-1:0] r_rp, n_rp;
    logic           r_out_valid, n_out_valid;

    // payload
    hdbc_pkg::t_mode r_mode;
    logic [7:0]     r_data;
    logic           r_sbp;
    logic [7:0]     r_store_q;
    logic           r_oob;
    logic [7:0]     r_fifo_q;
    logic [OW-1:0]  r_out_data, n_out_data;

    // backoff unit
    logic [7:0]     r_div_num, n_div_num;
    logic [8:0]     r_div_rem, n_div_rem;
    logic [8:0]     r_div_m, n_div_m;
    logic [2:0]     r_div_cnt, n_div_cnt;
    logic [15:0]    r_prod;

    // memory write strobes
    logic           st_we;
    logic           ff_we;
    logic [RXW-1:0] ff_nx;

    logic           s_acc;
    logic [TXW-1:0] rd_idx;
    logic [7:0]     store_byte;
    logic [RXW:0]   cnt_full;
    logic [15:0]    rs_next;
    logic [7:0]     rnd;
    logic [9:0]     div_t;
    logic [16:0]    dly_sum;

    assign s_acc       = i_s_tvalid && o_s_tready;
    assign o_s_tready  = (r_state == hdbc_pkg::ST_IDLE) && !r_out_valid;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign o_cfg_ready = 1'b1;

    assign rd_idx     = (hdbc_pkg::t_mode'(i_s_tuser) == hdbc_pkg::MD_LINE) ? r_cidx : r_sidx;
    assign store_byte = r_oob ? 8'd0 : r_store_q;
    assign ff_nx      = (r_wp == RX_LAST) ? '0 : r_wp + 1'b1;
    assign cnt_full   = (n_wp >= n_rp) ? ({1'b0, n_wp} - {1'b0, n_rp})
                                       : ({1'b0, n_wp} + RX_D - {1'b0, n_rp});
    assign rs_next    = 16'((r_rand << 7) - r_rand + 16'(hdbc_pkg::RAND_ADD));
    assign rnd        = rs_next[7:0] + rs_next[15:8];
    assign div_t      = {r_div_rem, r_div_num[7]};
    assign dly_sum    = {1'b0, r_ito} + {1'b0, r_prod};

    // ------------------------------------------------------------------
    // memories: registered read at acceptance, write-back in execute
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_oob     <= (rd_idx >= STORE_MAX);
            r_store_q <= r_store[rd_idx[SAW-1:0]];
            r_fifo_q  <= r_fifo[(r_rp == RX_LAST) ? '0 : r_rp + 1'b1];
        end
        if (st_we) begin
            r_store[r_flen[SAW-1:0]] <= r_data;
        end
        if (ff_we) begin
            r_fifo[ff_nx] <= r_data;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_mode <= hdbc_pkg::t_mode'(i_s_tuser);
            r_data <= i_s_tdata[7:0];
            r_sbp  <= i_s_tdata[8];
        end
        r_out_data <= n_out_data;
        r_div_num  <= n_div_num;
        r_div_rem  <= n_div_rem;
        r_div_m    <= n_div_m;
        r_div_cnt  <= n_div_cnt;
        if (r_state == hdbc_pkg::ST_MUL) begin
            r_prod <= (r_div_m == '0) ? 16'd0 : r_div_rem[7:0] * r_tpm;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hdbc_pkg::ST_IDLE;
            r_line      <= hdbc_pkg::LM_IDLE;
            r_ito       <= hdbc_pkg::ITO_RST;
            r_tpm       <= hdbc_pkg::TPM_RST;
            r_maxr      <= hdbc_pkg::MAXR_RST;
            r_jaml      <= hdbc_pkg::JAML_RST;
            r_flen      <= '0;
            r_sidx      <= '0;
            r_cidx      <= '0;
            r_active    <= 1'b0;
            r_first     <= 1'b0;
            r_armed     <= 1'b0;
            r_drv       <= 1'b0;
            r_retry     <= '0;
            r_jam       <= '0;
            r_pdly      <= '0;
            r_trem      <= '0;
            r_trun      <= 1'b0;
            r_rand      <= {8'd0, hdbc_pkg::SEED_RST};
            r_wp        <= RX_LAST;
            r_rp        <= RX_LAST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_line      <= n_line;
            r_flen      <= n_flen;
            r_sidx      <= n_sidx;
            r_cidx      <= n_cidx;
            r_active    <= n_active;
            r_first     <= n_first;
            r_armed     <= n_armed;
            r_drv       <= n_drv;
            r_retry     <= n_retry;
            r_jam       <= n_jam;
            r_pdly      <= n_pdly;
            r_trem      <= n_trem;
            r_trun      <= n_trun;
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_out_valid <= n_out_valid;
            r_rand      <= n_rand;
            if (i_cfg_valid) begin
                unique case (hdbc_pkg::t_cfg_idx'(i_cfg_index))
                    hdbc_pkg::CFG_ITO:  r_ito  <= i_cfg_data;
                    hdbc_pkg::CFG_TPM:  r_tpm  <= i_cfg_data[7:0];
                    hdbc_pkg::CFG_MAXR: r_maxr <= i_cfg_data[4:0];
                    hdbc_pkg::CFG_JAML: r_jaml <= i_cfg_data[3:0];
                    hdbc_pkg::CFG_SEED: r_rand <= {8'd0, i_cfg_data[7:0]};
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // next state and request execution
    // ------------------------------------------------------------------
    always_comb begin
        logic          txv;
        logic [7:0]    txb;
        logic          rxv;
        logic [7:0]    rxb;
        logic          acc;
        logic          drop;
        logic          last;
        logic          defer;
        logic [TXW-1:0] ci;

        txv   = 1'b0;
        txb   = 8'd0;
        rxv   = 1'b0;
        rxb   = 8'd0;
        acc   = 1'b0;
        drop  = 1'b0;
        last  = 1'b0;
        defer = 1'b0;
        ci    = r_cidx;

        n_state     = r_state;
        n_line      = r_line;
        n_flen      = r_flen;
        n_sidx      = r_sidx;
        n_cidx      = r_cidx;
        n_active    = r_active;
        n_first     = r_first;
        n_armed     = r_armed;
        n_drv       = r_drv;
        n_retry     = r_retry;
        n_jam       = r_jam;
        n_pdly      = r_pdly;
        n_trem      = r_trem;
        n_trun      = r_trun;
        n_rand      = r_rand;
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        n_div_num   = r_div_num;
        n_div_rem   = r_div_rem;
        n_div_m     = r_div_m;
        n_div_cnt   = r_div_cnt;
        st_we       = 1'b0;
        ff_we       = 1'b0;

        unique case (r_state)
            hdbc_pkg::ST_IDLE: begin
                if (s_acc) begin
                    n_state = hdbc_pkg::ST_EXEC;
                end
            end
            hdbc_pkg::ST_EXEC: begin
                n_state = hdbc_pkg::ST_IDLE;
                unique case (r_mode)
                    hdbc_pkg::MD_LOAD: begin
                        if ((r_line == hdbc_pkg::LM_IDLE || r_line == hdbc_pkg::LM_RX)
                                && r_flen < STORE_MAX) begin
                            st_we  = 1'b1;
                            n_flen = r_flen + 1'b1;
                            acc    = 1'b1;
                        end
                    end
                    hdbc_pkg::MD_SEND: begin
                        if (r_line == hdbc_pkg::LM_IDLE) begin
                            acc    = 1'b1;
                            n_cidx = '0;
                            if (r_flen != '0) begin
                                n_sidx   = '0;
                                n_active = 1'b1;
                                n_first  = 1'b1;
                                n_armed  = 1'b0;
                                n_drv    = 1'b1;
                            end
                        end else if (r_line == hdbc_pkg::LM_RX) begin
                            acc    = 1'b1;
                            n_pdly = r_ito;
                            n_line = hdbc_pkg::LM_PEND;
                        end
                    end
                    hdbc_pkg::MD_LINE: begin
                        unique case (r_line)
                            hdbc_pkg::LM_TX: begin
                                if (r_data == store_byte) begin
                                    ci     = (r_cidx < STORE_MAX) ? r_cidx + 1'b1 : r_cidx;
                                    n_cidx = ci;
                                    if (ci == r_flen) begin
                                        n_flen  = '0;
                                        n_retry = '0;
                                        n_trun  = 1'b0;
                                    end else begin
                                        n_trem = r_ito;
                                        n_trun = 1'b1;
                                    end
                                end else begin
                                    n_line  = hdbc_pkg::LM_JAM;
                                    n_trun  = 1'b0;
                                    n_sidx  = r_flen;
                                    txv     = 1'b1;
                                    n_retry = (r_retry < hdbc_pkg::RETRY_SAT) ? r_retry + 1'b1
                                                                              : r_retry;
                                    n_jam   = '0;
                                end
                            end
                            hdbc_pkg::LM_JAM: n_trun = 1'b0;
                            hdbc_pkg::LM_STOP: ;
                            hdbc_pkg::LM_PEND: begin
                                n_trem = r_pdly;
                                n_trun = 1'b1;
                                if (ff_nx != r_rp) begin
                                    ff_we = 1'b1;
                                    n_wp  = ff_nx;
                                end
                            end
                            default: begin
                                n_line = hdbc_pkg::LM_RX;
                                n_trem = r_ito;
                                n_trun = 1'b1;
                                if (ff_nx != r_rp) begin
                                    ff_we = 1'b1;
                                    n_wp  = ff_nx;
                                end
                            end
                        endcase
                    end
                    hdbc_pkg::MD_TICK: begin
                        if (r_trun) begin
                            if (r_trem > 16'd1) begin
                                n_trem = r_trem - 16'd1;
                            end else begin
                                n_trem = '0;
                                n_trun = 1'b0;
                                unique case (r_line)
                                    hdbc_pkg::LM_STOP: begin
                                        if (r_retry < r_maxr) begin
                                            // backoff: remainder computed serially
                                            n_rand    = rs_next;
                                            n_line    = hdbc_pkg::LM_PEND;
                                            n_div_num = rnd;
                                            n_div_rem = '0;
                                            n_div_m   = {r_retry, 4'd0};
                                            n_div_cnt = '0;
                                            n_state   = hdbc_pkg::ST_DIV;
                                        end else begin
                                            n_flen  = '0;
                                            n_retry = '0;
                                            n_line  = hdbc_pkg::LM_IDLE;
                                            drop    = 1'b1;
                                        end
                                    end
                                    hdbc_pkg::LM_PEND: begin
                                        n_line = hdbc_pkg::LM_IDLE;
                                        n_cidx = '0;
                                        if (r_flen != '0) begin
                                            n_sidx   = '0;
                                            n_active = 1'b1;
                                            n_first  = 1'b1;
                                            n_armed  = 1'b0;
                                            n_drv    = 1'b1;
                                        end
                                    end
                                    default: n_line = hdbc_pkg::LM_IDLE;
                                endcase
                            end
                        end
                    end
                    hdbc_pkg::MD_TXRDY: begin
                        if (r_active) begin
                            if (r_line == hdbc_pkg::LM_JAM) begin
                                n_jam = (r_jam < hdbc_pkg::JAM_SAT) ? r_jam + 1'b1 : r_jam;
                                if (n_jam < r_jaml) begin
                                    txv = 1'b1;
                                end else begin
                                    last = 1'b1;
                                end
                            end else if (r_sidx < r_flen) begin
                                if (r_line == hdbc_pkg::LM_RX) begin
                                    defer = 1'b1;
                                end else if (r_first && r_sbp) begin
                                    n_first = 1'b0;
                                    defer   = 1'b1;
                                end else begin
                                    n_first = 1'b0;
                                    txv     = 1'b1;
                                    txb     = store_byte;
                                    n_sidx  = r_sidx + 1'b1;
                                    n_line  = hdbc_pkg::LM_TX;
                                end
                            end else begin
                                last = 1'b1;
                            end
                            if (defer) begin
                                n_pdly   = r_ito;
                                n_trem   = r_ito;
                                n_trun   = 1'b1;
                                n_line   = hdbc_pkg::LM_PEND;
                                n_sidx   = r_flen;
                                n_active = 1'b0;
                            end
                            if (last) begin
                                n_active = 1'b0;
                                n_armed  = 1'b1;
                            end
                        end
                    end
                    hdbc_pkg::MD_TXDN: begin
                        if (r_armed) begin
                            n_armed = 1'b0;
                            n_drv   = 1'b0;
                            if (r_line == hdbc_pkg::LM_JAM) begin
                                n_line = hdbc_pkg::LM_STOP;
                                n_trem = r_ito;
                                n_trun = 1'b1;
                            end else begin
                                n_line = hdbc_pkg::LM_IDLE;
                            end
                        end
                    end
                    hdbc_pkg::MD_START: begin
                        if (r_line == hdbc_pkg::LM_IDLE) begin
                            n_line = hdbc_pkg::LM_RX;
                            n_trem = r_ito;
                            n_trun = 1'b1;
                        end
                    end
                    hdbc_pkg::MD_READ: begin
                        if (r_wp != r_rp) begin
                            n_rp = (r_rp == RX_LAST) ? '0 : r_rp + 1'b1;
                            rxv  = 1'b1;
                            rxb  = r_fifo_q;
                        end
                    end
                    default: ;
                endcase
                n_out_valid = 1'b1;
                n_out_data  = '0;
                n_out_data[0]     = txv;
                n_out_data[8:1]   = txb;
                n_out_data[9]     = n_drv;
                n_out_data[10]    = rxv;
                n_out_data[18:11] = rxb;
                n_out_data[19]    = acc;
                n_out_data[22:20] = n_line;
                n_out_data[23]    = drop;
                n_out_data[24 +: RXW] = cnt_full[RXW-1:0];
            end
            hdbc_pkg::ST_DIV: begin
                // one restoring step per cycle, MSB first
                n_div_rem = (div_t >= {1'b0, r_div_m}) ? 9'(div_t - {1'b0, r_div_m})
                                                       : div_t[8:0];
                n_div_num = {r_div_num[6:0], 1'b0};
                n_div_cnt = r_div_cnt + 1'b1;
                if (r_div_cnt == 3'd7) begin
                    n_state = hdbc_pkg::ST_MUL;
                end
            end
            hdbc_pkg::ST_MUL: begin
                n_state = hdbc_pkg::ST_SUM;
            end
            hdbc_pkg::ST_SUM: begin
                n_pdly  = dly_sum[16] ? 16'hFFFF : dly_sum[15:0];
                n_trem  = n_pdly;
                n_trun  = 1'b1;
                n_state = hdbc_pkg::ST_IDLE;
            end
            default: n_state = hdbc_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == hdbc_pkg::ST_EXEC && o_m_tvalid == 1'b0))
        else $error("request not executed after acceptance");

    a_flen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flen <= STORE_MAX)
        else $error("frame length beyond store");

    a_drop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[23]) |-> (o_m_tdata[22:20] == hdbc_pkg::LM_IDLE))
        else $error("dropped frame without return to idle");

    a_backoff_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hdbc_pkg::ST_SUM) |-> (r_line == hdbc_pkg::LM_PEND && !r_trun))
        else $error("backoff finishing outside send pending");

endmodule
